>>> design/ct3_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and types of the 3x3 census transform.
// Depends on nothing; every other file of the block uses it.
package ct3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int IMG_W      = 12;
  localparam int ROI_W      = 11;
  localparam int DIM_W      = 15;
  localparam int PIX_W      = 8;
  localparam int CODE_W     = 8;
  localparam int APB_DW     = 32;
  localparam int PADDR_W    = 5;
  localparam int REG_IDX_W  = 3;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROI_X        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROI_Y        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROI_WIDTH    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROI_HEIGHT   = 3'd5;

  localparam logic [IMG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [IMG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [ROI_W-1:0] RST_ROI_X        = 11'd1;
  localparam logic [ROI_W-1:0] RST_ROI_Y        = 11'd1;
  localparam logic [ROI_W-1:0] RST_ROI_WIDTH    = 11'd638;
  localparam logic [ROI_W-1:0] RST_ROI_HEIGHT   = 11'd478;

  typedef struct packed {
    logic [CODE_W-1:0] census_code;
    logic              frame_last;
  } result_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_wr_t;

endpackage

>>> design/ct3_pixel_if.sv
`timescale 1ns / 1ps
// Pixel request channel: valid/ready handshake with pixel and frame_start.
// Depends on ct3_pkg for the pixel width.
interface ct3_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [ct3_pkg::PIX_W-1:0]  pixel;
  logic                       frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

>>> design/ct3_code_if.sv
`timescale 1ns / 1ps
// Census code request channel: valid/ready handshake with code and last flag.
// Depends on ct3_pkg for the code width.
interface ct3_code_if;
  logic                       valid;
  logic                       ready;
  logic [ct3_pkg::CODE_W-1:0] census_code;
  logic                       frame_last;

  modport source (output valid, output census_code, output frame_last, input ready);
  modport sink   (input valid, input census_code, input frame_last, output ready);
endinterface

>>> design/census_transform_3x3_top.sv
`timescale 1ns / 1ps
// 3x3 census transform top level: APB registers, line-store pipeline, output queue.
// Depends on ct3_pkg, ct3_pixel_if, ct3_code_if, ct3_line_mem and ct3_out_fifo.
//
// The block takes one 8-bit pixel per clock in raster order and, for every
// center inside the region of interest (clipped to the one-pixel image
// border), emits an 8-bit census code when the lower-right neighbor of that
// center arrives; bit k is set when neighbor k (upper-left, up, upper-right,
// left, right, lower-left, down, lower-right) is greater than or equal to the
// center, and frame_last flags the code of the region's last center. A pixel
// request with frame_start set restarts the position at row 0, column 0.
// Throughput is one pixel per clock while the code sink keeps up: the line
// stores are synchronous RAMs read at the pixel's column on acceptance and
// written back from stage 1, with a forwarding path for two back-to-back
// pixels at the same column. Code valid rises once a code is in the queue.
// Codes wait in a four-entry queue; pixel ready drops only when pixels in
// flight plus queued codes fill those four slots, i.e. when the code sink
// stalls. The line stores need no clearing pass after reset: their contents
// are only consumed once the center's row and the row above have been written.
// Registers (APB, byte address 4*index): image_width, image_height, roi_x,
// roi_y, roi_width, roi_height. Write them only while the block is idle.
module census_transform_3x3_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ct3_pixel_if.sink                    pix_in,
  ct3_code_if.source                   code_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ct3_pkg::PADDR_W-1:0]  paddr,
  input  logic [ct3_pkg::APB_DW-1:0]   pwdata,
  output logic [ct3_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import ct3_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [IMG_W-1:0]     img_w_q, img_h_q;
  logic [ROI_W-1:0]     roi_x_q, roi_y_q, roi_w_q, roi_h_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= RST_IMAGE_WIDTH;
      img_h_q <= RST_IMAGE_HEIGHT;
      roi_x_q <= RST_ROI_X;
      roi_y_q <= RST_ROI_Y;
      roi_w_q <= RST_ROI_WIDTH;
      roi_h_q <= RST_ROI_HEIGHT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  img_w_q <= pwdata[IMG_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q <= pwdata[IMG_W-1:0];
        REG_ROI_X:        roi_x_q <= pwdata[ROI_W-1:0];
        REG_ROI_Y:        roi_y_q <= pwdata[ROI_W-1:0];
        REG_ROI_WIDTH:    roi_w_q <= pwdata[ROI_W-1:0];
        REG_ROI_HEIGHT:   roi_h_q <= pwdata[ROI_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(img_w_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(img_h_q);
      REG_ROI_X:        prdata = APB_DW'(roi_x_q);
      REG_ROI_Y:        prdata = APB_DW'(roi_y_q);
      REG_ROI_WIDTH:    prdata = APB_DW'(roi_w_q);
      REG_ROI_HEIGHT:   prdata = APB_DW'(roi_h_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Effective image size and clipped region
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIM_W-1:0] x_first, x_last, x_lim, x_hi;
  logic [DIM_W-1:0] y_first, y_last, y_lim, y_hi;
  logic             x_ok, y_ok;

  always_comb begin
    // Clamp the frame size to [3, MAX]
    w_eff = DIM_W'(img_w_q);
    if (w_eff < DIM_W'(3)) w_eff = DIM_W'(3);
    else if (w_eff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = DIM_W'(img_h_q);
    if (h_eff < DIM_W'(3)) h_eff = DIM_W'(3);
    else if (h_eff > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);

    // Clip the region to [1, size - 2] on each axis
    x_first = (roi_x_q == '0) ? DIM_W'(1) : DIM_W'(roi_x_q);
    x_last  = DIM_W'(roi_x_q) + DIM_W'(roi_w_q) - DIM_W'(1);
    x_lim   = w_eff - DIM_W'(2);
    x_hi    = (x_last > x_lim) ? x_lim : x_last;
    x_ok    = (roi_w_q != '0) && (x_first <= x_hi);

    y_first = (roi_y_q == '0) ? DIM_W'(1) : DIM_W'(roi_y_q);
    y_last  = DIM_W'(roi_y_q) + DIM_W'(roi_h_q) - DIM_W'(1);
    y_lim   = h_eff - DIM_W'(2);
    y_hi    = (y_last > y_lim) ? y_lim : y_last;
    y_ok    = (roi_h_q != '0) && (y_first <= y_hi);
  end

  // Register the clipped bounds; they are used in stage 1, the cycle after acceptance.
  logic [COL_W-1:0] x_lo_q, x_hi_q;
  logic [ROW_W-1:0] y_lo_q, y_hi_q;
  logic             roi_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lo_q   <= '0;
      x_hi_q   <= '0;
      y_lo_q   <= '0;
      y_hi_q   <= '0;
      roi_ok_q <= 1'b0;
    end else begin
      x_lo_q   <= x_first[COL_W-1:0];
      x_hi_q   <= x_hi[COL_W-1:0];
      y_lo_q   <= y_first[ROW_W-1:0];
      y_hi_q   <= y_hi[ROW_W-1:0];
      roi_ok_q <= x_ok & y_ok;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: position tracking and line-store read
  // ---------------------------------------------------------------------
  logic [COL_W-1:0]       col_q, col_d, col_cur;
  logic [ROW_W-1:0]       row_q, row_d, row_cur;
  logic [DIM_W-1:0]       col_inc, row_inc;
  logic                   in_acc;
  logic [OFIFO_CNT_W-1:0] fifo_cnt;
  logic [OFIFO_CNT_W:0]   in_flight;
  logic                   s1_valid_q, s2_valid_q;

  // Count every pixel in flight as a possible code so the queue never overflows.
  assign in_flight   = (OFIFO_CNT_W + 1)'(fifo_cnt) + (OFIFO_CNT_W + 1)'(s1_valid_q)
                     + (OFIFO_CNT_W + 1)'(s2_valid_q);
  assign pix_in.ready = (in_flight < (OFIFO_CNT_W + 1)'(OFIFO_DEPTH));
  assign in_acc       = pix_in.valid & pix_in.ready;

  always_comb begin
    col_cur = pix_in.frame_start ? '0 : col_q;
    row_cur = pix_in.frame_start ? '0 : row_q;
    // Restart a position that lies beyond a newly configured size
    if (DIM_W'(col_cur) >= w_eff) col_cur = '0;
    if (DIM_W'(row_cur) >= h_eff) row_cur = '0;

    col_inc = DIM_W'(col_cur) + DIM_W'(1);
    row_inc = DIM_W'(row_cur) + DIM_W'(1);
    col_d   = col_inc[COL_W-1:0];
    row_d   = row_cur;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line-store data back, write-back, window shift
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [PIX_W-1:0] s1_px_q;
  logic             s1_fwd_q;
  logic [PIX_W-1:0] fwd_up_q, fwd_mid_q;
  logic [PIX_W-1:0] rd_up, rd_mid, up_eff, mid_eff;
  line_wr_t         line_wr;

  assign up_eff  = s1_fwd_q ? fwd_up_q  : rd_up;
  assign mid_eff = s1_fwd_q ? fwd_mid_q : rd_mid;

  assign line_wr.en     = s1_valid_q;
  assign line_wr.addr   = s1_col_q;
  assign line_wr.upper  = mid_eff;
  assign line_wr.middle = s1_px_q;

  ct3_line_mem u_line_mem (
    .clk_i       (clk_i),
    .rd_en_i     (in_acc),
    .rd_addr_i   (col_cur),
    .wr_i        (line_wr),
    .rd_upper_o  (rd_up),
    .rd_middle_o (rd_mid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      // The RAM returns stale data when the write-back hits the read address
      s1_fwd_q   <= in_acc & s1_valid_q & (col_cur == s1_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q  <= col_cur;
      s1_row_q  <= row_cur;
      s1_px_q   <= pix_in.pixel;
      fwd_up_q  <= mid_eff;
      fwd_mid_q <= s1_px_q;
    end
  end

  // Decide whether the center one column and one row back is emitted
  logic [COL_W-1:0] cx;
  logic [ROW_W-1:0] cy;
  logic             s1_emit, s1_last;

  always_comb begin
    cx      = s1_col_q - 1'b1;
    cy      = s1_row_q - 1'b1;
    s1_emit = s1_valid_q && roi_ok_q
           && (s1_col_q >= COL_W'(2)) && (s1_row_q >= ROW_W'(2))
           && (cx >= x_lo_q) && (cx <= x_hi_q)
           && (cy >= y_lo_q) && (cy <= y_hi_q);
    s1_last = (cx == x_hi_q) && (cy == y_hi_q);
  end

  // 3x3 window, [row][column], row 0 on top, column 2 newest
  logic [PIX_W-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= up_eff;
      win_q[1][2] <= mid_eff;
      win_q[2][2] <= s1_px_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: compare against the center and queue the code
  // ---------------------------------------------------------------------
  logic    s2_last_q;
  result_t s2_res, fifo_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit) begin
      s2_last_q <= s1_last;
    end
  end

  always_comb begin
    s2_res.census_code[0] = (win_q[0][0] >= win_q[1][1]);
    s2_res.census_code[1] = (win_q[0][1] >= win_q[1][1]);
    s2_res.census_code[2] = (win_q[0][2] >= win_q[1][1]);
    s2_res.census_code[3] = (win_q[1][0] >= win_q[1][1]);
    s2_res.census_code[4] = (win_q[1][2] >= win_q[1][1]);
    s2_res.census_code[5] = (win_q[2][0] >= win_q[1][1]);
    s2_res.census_code[6] = (win_q[2][1] >= win_q[1][1]);
    s2_res.census_code[7] = (win_q[2][2] >= win_q[1][1]);
    s2_res.frame_last     = s2_last_q;
  end

  ct3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (s2_res),
    .pop_i       (code_out.ready),
    .out_valid_o (code_out.valid),
    .out_data_o  (fifo_out),
    .count_o     (fifo_cnt)
  );

  assign code_out.census_code = fifo_out.census_code;
  assign code_out.frame_last  = fifo_out.frame_last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= (OFIFO_CNT_W + 1)'(OFIFO_DEPTH))
    else $error("pixels in flight plus queued codes exceed the queue depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (fifo_cnt < OFIFO_CNT_W'(OFIFO_DEPTH)) || code_out.ready)
    else $error("code pushed into a full queue");

  a_fwd_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fwd_q |-> s1_valid_q && $past(s1_valid_q))
    else $error("forwarding without a preceding write-back");

  a_s2_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> $past(s1_valid_q, 2))
    else $error("code stage valid without a pixel behind it");

endmodule

>>> design/ct3_line_mem.sv
`timescale 1ns / 1ps
// Upper and middle line stores: one write and one registered read per cycle.
// Depends on ct3_pkg (widths, line_wr_t).
module ct3_line_mem (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [ct3_pkg::COL_W-1:0]  rd_addr_i,
  input  ct3_pkg::line_wr_t          wr_i,
  output logic [ct3_pkg::PIX_W-1:0]  rd_upper_o,
  output logic [ct3_pkg::PIX_W-1:0]  rd_middle_o
);
  import ct3_pkg::*;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      upper_mem[wr_i.addr]  <= wr_i.upper;
      middle_mem[wr_i.addr] <= wr_i.middle;
    end
  end

  // Old data on a same-address collision; the caller forwards around it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_upper_o  <= upper_mem[rd_addr_i];
      rd_middle_o <= middle_mem[rd_addr_i];
    end
  end

endmodule

>>> design/ct3_out_fifo.sv
`timescale 1ns / 1ps
// Small result queue between the census pipeline and the output channel.
// Depends on ct3_pkg (depth, result_t).
module ct3_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  ct3_pkg::result_t                push_data_i,
  input  logic                            pop_i,
  output logic                            out_valid_o,
  output ct3_pkg::result_t                out_data_o,
  output logic [ct3_pkg::OFIFO_CNT_W-1:0] count_o
);
  import ct3_pkg::*;

  result_t                slot_q [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OFIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OFIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign count_o     = cnt_q;
  assign do_pop      = pop_i & out_valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
